[rtl/core/gbn_pkg.sv]
// Shared types, constants and command/status structs of the go-back-n sender.
// No dependencies; every other file of the block but gbn_ram and gbn_chan_if uses it by scoped names.
package gbn_pkg;

  localparam int WIN_SLOTS    = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_SPACE    = 2 * WIN_SLOTS;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int CNT_W        = $clog2(WIN_SLOTS + 1);
  localparam int WIN_W        = 3;
  localparam int OP_W         = 2;

  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

  typedef logic [WIN_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_num;
    logic                    ack_ok;
    logic [SEQ_W-1:0]        timer_tag;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    tx_valid;
    logic [SEQ_W-1:0]        tx_seq;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic                    timer_start;
    logic [SEQ_W-1:0]        timer_start_seq;
    logic                    timer_stop;
    logic [SEQ_W-1:0]        timer_stop_seq;
    logic                    window_full;
    logic                    last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // request accepted this cycle
    logic load_retx;  // capture a retransmit result from the RAM read data
    logic next_read;  // step to the next outstanding packet
  } gbn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic retx_req;   // offered request is a timeout with packets outstanding
    logic retx_last;  // current retransmit result is the final one
  } gbn_sts_t;

endpackage

[rtl/core/gbn_chan_if.sv]
// Valid/ready channel interface with source and sink modports.
// The payload type is a parameter; the block uses gbn_pkg types for it.
interface gbn_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/gbn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/gbn_ctrl.sv]
// Controller state machine of the go-back-n sender.
// Depends on gbn_pkg for the command and status structs.
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HOLD  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_SHOW  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_HOLD) || (state_r == ST_SHOW);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.retx_req ? ST_FETCH : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd.load_retx = 1'b1;
        state_nxt     = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          if (sts.retx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_read = 1'b1;
            state_nxt     = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/gbn_dpath.sv]
// Datapath of the go-back-n sender: window registers, payload RAM, result register.
// Depends on gbn_pkg and gbn_ram.
module gbn_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  gbn_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  gbn_pkg::cfg_word_t cfg_data,
  input  gbn_pkg::gbn_cmd_t  cmd,
  output gbn_pkg::gbn_sts_t  sts,
  output gbn_pkg::out_item_t out_data
);

  localparam int SEQ_W = gbn_pkg::SEQ_W;
  localparam int CNT_W = gbn_pkg::CNT_W;

  gbn_pkg::cfg_word_t win_r;
  logic [SEQ_W-1:0]   base_r, base_nxt;
  logic [SEQ_W-1:0]   next_r, next_nxt;
  logic [CNT_W-1:0]   outs_r, outs_nxt;
  logic [SEQ_W-1:0]   idx_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SEQ_W-1:0]   tag_r;
  gbn_pkg::out_item_t out_r;

  gbn_pkg::out_item_t            res, rt;
  logic [CNT_W-1:0]              weff;
  logic [SEQ_W-1:0]              ack_gap;
  logic                          ack_hit;
  logic                          send_ok;
  logic                          ram_we, ram_re;
  logic [SEQ_W-1:0]              ram_raddr;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] ram_rdata;

  // Clamp the window register into 1..WIN_SLOTS
  always_comb begin
    if (win_r == '0) begin
      weff = CNT_W'(1);
    end else if (win_r > gbn_pkg::WIN_W'(gbn_pkg::WIN_SLOTS)) begin
      weff = CNT_W'(gbn_pkg::WIN_SLOTS);
    end else begin
      weff = CNT_W'(win_r);
    end
  end

  assign ack_gap = in_data.ack_num - base_r;
  assign ack_hit = in_data.ack_ok && (ack_gap < outs_r);
  assign send_ok = (outs_r < weff);

  assign sts.retx_req  = (in_data.op == gbn_pkg::OP_TIMEOUT) && (outs_r != '0);
  assign sts.retx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  // Single-result requests: window update and its result
  always_comb begin
    res      = '0;
    base_nxt = base_r;
    next_nxt = next_r;
    outs_nxt = outs_r;
    ram_we   = 1'b0;
    case (in_data.op)
      gbn_pkg::OP_SEND: begin
        if (send_ok) begin
          ram_we         = cmd.take;
          next_nxt       = next_r + SEQ_W'(1);
          outs_nxt       = outs_r + CNT_W'(1);
          res.accepted   = 1'b1;
          res.tx_valid   = 1'b1;
          res.tx_seq     = next_r;
          res.tx_payload = in_data.payload;
          if (outs_r == '0) begin
            res.timer_start     = 1'b1;
            res.timer_start_seq = next_r;
          end
        end
      end
      gbn_pkg::OP_ACK: begin
        if (ack_hit) begin
          base_nxt           = in_data.ack_num + SEQ_W'(1);
          outs_nxt           = outs_r - CNT_W'(ack_gap) - CNT_W'(1);
          res.timer_stop     = 1'b1;
          res.timer_stop_seq = base_r;
          if (outs_nxt != '0) begin
            res.timer_start     = 1'b1;
            res.timer_start_seq = base_nxt;
          end
        end
      end
      gbn_pkg::OP_TIMEOUT: begin
        res.timer_start     = 1'b1;
        res.timer_start_seq = in_data.timer_tag;
        res.timer_stop      = 1'b1;
        res.timer_stop_seq  = in_data.timer_tag;
      end
      default: begin
      end
    endcase
    res.window_full = (outs_nxt >= weff);
    res.last        = 1'b1;
  end

  // Retransmit result built from the RAM read data
  always_comb begin
    rt            = '0;
    rt.tx_valid   = 1'b1;
    rt.tx_seq     = base_r + idx_r;
    rt.tx_payload = ram_rdata;
    if (idx_r == '0) begin
      rt.timer_start     = 1'b1;
      rt.timer_start_seq = tag_r;
      rt.timer_stop      = 1'b1;
      rt.timer_stop_seq  = tag_r;
    end
    rt.window_full = (outs_r >= weff);
    rt.last        = sts.retx_last;
  end

  assign ram_re    = (cmd.take && sts.retx_req) || cmd.next_read;
  assign ram_raddr = cmd.take ? base_r : (base_r + idx_r + SEQ_W'(1));

  gbn_ram #(
    .WIDTH (gbn_pkg::PAYLOAD_BITS),
    .DEPTH (gbn_pkg::SEQ_SPACE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_r),
    .wdata (in_data.payload),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= gbn_pkg::WIN_RESET;
      base_r <= '0;
      next_r <= '0;
      outs_r <= '0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_data;
      end
      if (cmd.take) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        outs_r <= outs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_r <= '0;
      cnt_r <= outs_r;
      tag_r <= in_data.timer_tag;
    end else if (cmd.next_read) begin
      idx_r <= idx_r + SEQ_W'(1);
    end
    if (cmd.take && !sts.retx_req) begin
      out_r <= res;
    end else if (cmd.load_retx) begin
      out_r <= rt;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/go_back_n_sender.sv]
// Top level of the go-back-n sender window: controller plus datapath.
// Depends on gbn_pkg, gbn_chan_if, gbn_ctrl, gbn_dpath and gbn_ram.
//
// One request is in flight at a time. A send, an ack or any other request
// that yields a single result is taken and its result sits in the output
// register from the next cycle; the next request is taken the cycle after
// that result is taken. A timeout with N packets outstanding produces N
// results, base first: each packet costs one registered read of the
// payload RAM and then its turn on the output. The payload RAM is not
// cleared after reset; only entries that were written are ever read. The
// window register port is always ready and should be written only while
// no request is in flight.
module go_back_n_sender (
  input logic        clk,
  input logic        rst_n,
  gbn_chan_if.sink   in_req,
  gbn_chan_if.source out_rsp,
  gbn_chan_if.sink   cfg_wr
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;
  logic              cfg_we;

  // The window register takes a write in any cycle
  assign cfg_wr.ready = 1'b1;
  assign cfg_we       = cfg_wr.valid;

  // Sequence the request, the retransmit reads and the output handshake
  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the window state, the payload store and the result register
  gbn_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_req.data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_wr.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_rsp.data)
  );

endmodule

[rtl/core/gbn_checker.sv]
// Port-level assertions of the go-back-n sender and their bind.
// Depends on gbn_pkg and go_back_n_sender.
module gbn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [gbn_pkg::OP_W-1:0] in_op,
  input logic               out_valid,
  input logic               out_ready,
  input gbn_pkg::out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No request is taken while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  // A request other than a timeout shows its result in the next cycle
  a_single_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != gbn_pkg::OP_TIMEOUT) |=> out_valid && out_data.last)
    else $error("single result missing");

  // Only retransmits span several results, and they always carry a packet
  a_multi_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.tx_valid && !out_data.accepted)
    else $error("non-final result without packet");

  // An accepted send carries its packet and never stops the timer
  a_accept_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.tx_valid && !out_data.timer_stop)
    else $error("accepted send malformed");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .in_op     (in_req.data.op),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_data  (out_rsp.data)
);
